@@ rtl/core/qnm_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the quadrature NCO mixer.
// Used by the controller, the datapath and the top level; no dependencies.
package qnm_pkg;

    // Fixed formats of the configuration registers
    localparam int CFG_W     = 32;
    localparam int CFG_IDX_W = 2;
    localparam int MG_W      = 16;
    localparam int ROT_FRAC  = 30;
    localparam int GAIN_FRAC = 14;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ROT_COS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROT_SIN  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIX_GAIN = 2'd2;

    // Register reset values
    localparam logic signed [CFG_W-1:0] ROT_COS_RST  = 32'sd1073741824;
    localparam logic signed [CFG_W-1:0] ROT_SIN_RST  = 32'sd0;
    localparam logic [MG_W-1:0]         MIX_GAIN_RST = 16'd18022;

    // Controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ISSUE_A,
        ST_WAIT_A,
        ST_SAT,
        ST_ISSUE_B,
        ST_WAIT_B,
        ST_ISSUE_C,
        ST_WAIT_C
    } t_state;

    // Multiply operation tags: operands on issue, destination on writeback
    typedef enum logic [3:0] {
        TAG_QC,     // vq * cos
        TAG_IS,     // vi * sin
        TAG_IC,     // vi * cos
        TAG_QS,     // vq * sin
        TAG_QQ,     // vq * vq
        TAG_II,     // vi * vi
        TAG_GQ,     // g * oq
        TAG_GI,     // g * oi
        TAG_XIOQ,   // xi * oq
        TAG_XQOI,   // xq * oi
        TAG_XQOQ,   // xq * oq
        TAG_XIOI,   // xi * oi
        TAG_YI,     // pi * mix_gain
        TAG_YQ      // pq * mix_gain
    } t_tag;

    // Rounding shift applied to a product
    typedef enum logic [1:0] {
        SH_ROT,
        SH_OSC,
        SH_GAIN
    } t_shift;

    // Controller to datapath
    typedef struct packed {
        logic load;     // latch the input sample
        logic sat;      // saturate the rotated vector and the gain
        logic issue;    // start a multiply
        t_tag tag;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic busy;     // multiplier pipeline holds an operation
        logic out_free; // output register free at the next edge
    } t_stat;

    function automatic t_shift tag_shift(input t_tag tag);
        t_shift sh;
        case (tag) inside
            TAG_QC, TAG_IS, TAG_IC, TAG_QS: sh = SH_ROT;
            TAG_YI, TAG_YQ:                 sh = SH_GAIN;
            default:                        sh = SH_OSC;
        endcase
        return sh;
    endfunction

endpackage

@@ rtl/core/qnm_ctrl.sv @@
`timescale 1ns / 1ps
// Sequencer for the quadrature NCO mixer: issues the three multiply phases.
// Depends on qnm_pkg.
module qnm_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  qnm_pkg::t_stat i_stat,
    output qnm_pkg::t_cmd  o_cmd
);
    import qnm_pkg::*;

    localparam logic [2:0] LAST_A = 3'd5;
    localparam logic [2:0] LAST_B = 3'd5;
    localparam logic [2:0] LAST_C = 3'd1;

    t_state     r_state, n_state;
    logic [2:0] r_step, n_step;
    logic       w_accept;
    logic       w_issue_c;

    assign w_accept  = (r_state == ST_IDLE) && i_in_valid;
    // first mixer product waits for a free output register
    assign w_issue_c = (r_step != 3'd0) || i_stat.out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = ST_ISSUE_A;
                    n_step  = '0;
                end
            end
            ST_ISSUE_A: begin
                n_step = r_step + 3'd1;
                if (r_step == LAST_A) begin
                    n_state = ST_WAIT_A;
                    n_step  = '0;
                end
            end
            ST_WAIT_A: begin
                if (!i_stat.busy) n_state = ST_SAT;
            end
            ST_SAT: begin
                n_state = ST_ISSUE_B;
            end
            ST_ISSUE_B: begin
                n_step = r_step + 3'd1;
                if (r_step == LAST_B) begin
                    n_state = ST_WAIT_B;
                    n_step  = '0;
                end
            end
            ST_WAIT_B: begin
                if (!i_stat.busy) n_state = ST_ISSUE_C;
            end
            ST_ISSUE_C: begin
                if (w_issue_c) begin
                    n_step = r_step + 3'd1;
                    if (r_step == LAST_C) begin
                        n_state = ST_WAIT_C;
                        n_step  = '0;
                    end
                end
            end
            ST_WAIT_C: begin
                if (!i_stat.busy) n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
                n_step  = '0;
            end
        endcase
    end

    // Outputs
    always_comb begin
        o_cmd       = '0;
        o_cmd.tag   = TAG_QC;
        o_cmd.load  = w_accept;
        o_in_stall  = (r_state != ST_IDLE);
        unique case (r_state)
            ST_ISSUE_A: begin
                o_cmd.issue = 1'b1;
                case (r_step)
                    3'd0:    o_cmd.tag = TAG_QC;
                    3'd1:    o_cmd.tag = TAG_IS;
                    3'd2:    o_cmd.tag = TAG_IC;
                    3'd3:    o_cmd.tag = TAG_QS;
                    3'd4:    o_cmd.tag = TAG_QQ;
                    default: o_cmd.tag = TAG_II;
                endcase
            end
            ST_SAT: begin
                o_cmd.sat = 1'b1;
            end
            ST_ISSUE_B: begin
                o_cmd.issue = 1'b1;
                case (r_step)
                    3'd0:    o_cmd.tag = TAG_GQ;
                    3'd1:    o_cmd.tag = TAG_GI;
                    3'd2:    o_cmd.tag = TAG_XIOQ;
                    3'd3:    o_cmd.tag = TAG_XQOI;
                    3'd4:    o_cmd.tag = TAG_XQOQ;
                    default: o_cmd.tag = TAG_XIOI;
                endcase
            end
            ST_ISSUE_C: begin
                o_cmd.issue = w_issue_c;
                o_cmd.tag   = (r_step == 3'd0) ? TAG_YI : TAG_YQ;
            end
            default: begin
            end
        endcase
    end

endmodule

@@ rtl/core/qnm_datapath.sv @@
`timescale 1ns / 1ps
// Datapath for the quadrature NCO mixer: config registers, oscillator state,
// a shared five-stage rounding multiplier and the writeback accumulators.
// Depends on qnm_pkg.
module qnm_datapath #(
    parameter int SAMPLE_WIDTH = 16,
    parameter int OSC_WIDTH    = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [qnm_pkg::CFG_IDX_W-1:0]       i_cfg_addr,
    input  logic [qnm_pkg::CFG_W-1:0]           i_cfg_wdata,
    input  logic signed [SAMPLE_WIDTH-1:0]      i_i_in,
    input  logic signed [SAMPLE_WIDTH-1:0]      i_q_in,
    input  logic                                i_out_stall,
    output logic                                o_out_valid,
    output logic signed [SAMPLE_WIDTH-1:0]      o_i_out,
    output logic signed [SAMPLE_WIDTH-1:0]      o_q_out,
    input  qnm_pkg::t_cmd                       i_cmd,
    output qnm_pkg::t_stat                      o_stat
);
    import qnm_pkg::*;

    localparam int OW   = OSC_WIDTH;
    localparam int SW   = SAMPLE_WIDTH;
    localparam int OSC_FRAC = OW - 2;
    // magnitude width: oscillator, rotation words and mixer sums all fit
    localparam int MW0  = (OW > SW + 2) ? OW : SW + 2;
    localparam int MW   = (MW0 > CFG_W) ? MW0 : CFG_W;
    localparam int HW   = (MW + 1) / 2;     // low half of operand b
    localparam int LW   = MW - HW;          // high half of operand b
    localparam int OPW  = MW + 1;           // signed operand width
    localparam int SUMW = 2 * MW + 1;       // full product
    localparam int PW   = MW + 4;           // rounded product, signed
    localparam int AW   = PW + 1;           // accumulators

    localparam longint unsigned GAIN_NUM = (64'd39 << OSC_FRAC) + 64'd10;
    localparam longint unsigned GAIN_U   = GAIN_NUM / 20;
    localparam logic signed [AW-1:0] GAIN_REF = AW'(GAIN_U);
    localparam logic signed [OW-1:0] VEC_ONE  = {2'b01, {OSC_FRAC{1'b0}}};

    localparam logic signed [AW-1:0] OSC_MAX = {{(AW-OW+1){1'b0}}, {(OW-1){1'b1}}};
    localparam logic signed [AW-1:0] OSC_MIN = ~OSC_MAX;
    localparam logic signed [AW-1:0] SMP_MAX = {{(AW-SW+1){1'b0}}, {(SW-1){1'b1}}};
    localparam logic signed [AW-1:0] SMP_MIN = ~SMP_MAX;

    localparam logic [SUMW-1:0] RND_ROT  = SUMW'(1) << (ROT_FRAC - 1);
    localparam logic [SUMW-1:0] RND_OSC  = SUMW'(1) << (OSC_FRAC - 1);
    localparam logic [SUMW-1:0] RND_GAIN = SUMW'(1) << (GAIN_FRAC - 1);

    function automatic logic signed [OW-1:0] sat_osc(input logic signed [AW-1:0] v);
        logic signed [AW-1:0] c;
        c = v;
        if (v > OSC_MAX) c = OSC_MAX;
        if (v < OSC_MIN) c = OSC_MIN;
        return c[OW-1:0];
    endfunction

    function automatic logic signed [SW-1:0] sat_smp(input logic signed [AW-1:0] v);
        logic signed [AW-1:0] c;
        c = v;
        if (v > SMP_MAX) c = SMP_MAX;
        if (v < SMP_MIN) c = SMP_MIN;
        return c[SW-1:0];
    endfunction

    // Configuration and oscillator state
    logic signed [CFG_W-1:0] r_rot_cos, r_rot_sin;
    logic [MG_W-1:0]         r_mix_gain;
    logic signed [OW-1:0]    r_vq, r_vi;
    // Per-item working registers
    logic signed [SW-1:0]    r_xi, r_xq;
    logic signed [OW-1:0]    r_oq, r_oi, r_g;
    logic signed [AW-1:0]    r_acc_q, r_acc_i, r_acc_g;
    logic signed [SW-1:0]    r_yi, r_yq;
    logic                    r_out_valid;

    // Multiplier pipeline
    logic                    r_v1, r_v2, r_v3, r_v4, r_v5;
    t_tag                    r_s1_tag, r_s2_tag, r_s3_tag, r_s4_tag, r_s5_tag;
    logic                    r_s1_neg, r_s2_neg, r_s3_neg, r_s4_neg;
    logic [MW-1:0]           r_s1_ma, r_s1_mb;
    logic [MW+HW-1:0]        r_s2_plo;
    logic [MW+LW-1:0]        r_s2_phi;
    logic [SUMW-1:0]         r_s3_sum;
    logic [PW-1:0]           r_s4_mag;
    logic signed [PW-1:0]    r_s5_res;

    logic signed [OPW-1:0]   w_opa, w_opb;
    logic                    n_s1_neg;
    logic [MW-1:0]           n_s1_ma, n_s1_mb;
    logic [SUMW-1:0]         n_rnd;
    logic [PW-1:0]           n_s4_mag;
    logic signed [PW-1:0]    n_s5_res;
    logic signed [AW-1:0]    w_res;
    logic                    w_out_take;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rot_cos  <= ROT_COS_RST;
            r_rot_sin  <= ROT_SIN_RST;
            r_mix_gain <= MIX_GAIN_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_ROT_COS:  r_rot_cos  <= $signed(i_cfg_wdata);
                CFG_ROT_SIN:  r_rot_sin  <= $signed(i_cfg_wdata);
                CFG_MIX_GAIN: r_mix_gain <= i_cfg_wdata[MG_W-1:0];
                default: ;
            endcase
        end
    end

    // Operand select by tag
    always_comb begin
        w_opa = '0;
        w_opb = '0;
        case (i_cmd.tag)
            TAG_QC:   begin w_opa = OPW'(r_vq);    w_opb = OPW'(r_rot_cos); end
            TAG_IS:   begin w_opa = OPW'(r_vi);    w_opb = OPW'(r_rot_sin); end
            TAG_IC:   begin w_opa = OPW'(r_vi);    w_opb = OPW'(r_rot_cos); end
            TAG_QS:   begin w_opa = OPW'(r_vq);    w_opb = OPW'(r_rot_sin); end
            TAG_QQ:   begin w_opa = OPW'(r_vq);    w_opb = OPW'(r_vq);      end
            TAG_II:   begin w_opa = OPW'(r_vi);    w_opb = OPW'(r_vi);      end
            TAG_GQ:   begin w_opa = OPW'(r_g);     w_opb = OPW'(r_oq);      end
            TAG_GI:   begin w_opa = OPW'(r_g);     w_opb = OPW'(r_oi);      end
            TAG_XIOQ: begin w_opa = OPW'(r_xi);    w_opb = OPW'(r_oq);      end
            TAG_XQOI: begin w_opa = OPW'(r_xq);    w_opb = OPW'(r_oi);      end
            TAG_XQOQ: begin w_opa = OPW'(r_xq);    w_opb = OPW'(r_oq);      end
            TAG_XIOI: begin w_opa = OPW'(r_xi);    w_opb = OPW'(r_oi);      end
            TAG_YI: begin
                w_opa = OPW'(r_acc_q);
                w_opb = $signed({{(OPW-MG_W){1'b0}}, r_mix_gain});
            end
            TAG_YQ: begin
                w_opa = OPW'(r_acc_i);
                w_opb = $signed({{(OPW-MG_W){1'b0}}, r_mix_gain});
            end
            default: ;
        endcase
    end

    // Stage 1: sign and magnitudes
    assign n_s1_neg = w_opa[OPW-1] ^ w_opb[OPW-1];
    assign n_s1_ma  = w_opa[OPW-1] ? MW'(-w_opa) : MW'(w_opa);
    assign n_s1_mb  = w_opb[OPW-1] ? MW'(-w_opb) : MW'(w_opb);

    // Stage 4: round half away from zero on the magnitude, then shift
    always_comb begin
        n_rnd    = '0;
        n_s4_mag = '0;
        case (tag_shift(r_s3_tag))
            SH_ROT: begin
                n_rnd    = r_s3_sum + RND_ROT;
                n_s4_mag = PW'(n_rnd >> ROT_FRAC);
            end
            SH_OSC: begin
                n_rnd    = r_s3_sum + RND_OSC;
                n_s4_mag = PW'(n_rnd >> OSC_FRAC);
            end
            SH_GAIN: begin
                n_rnd    = r_s3_sum + RND_GAIN;
                n_s4_mag = PW'(n_rnd >> GAIN_FRAC);
            end
            default: ;
        endcase
    end

    // Stage 5: restore sign
    assign n_s5_res = r_s4_neg ? -$signed(r_s4_mag) : $signed(r_s4_mag);

    // Pipeline valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else begin
            r_v1 <= i_cmd.issue;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
        end
    end

    // Pipeline payload; products split over two half-width multipliers
    always_ff @(posedge i_clk) begin
        r_s1_tag <= i_cmd.tag;
        r_s1_neg <= n_s1_neg;
        r_s1_ma  <= n_s1_ma;
        r_s1_mb  <= n_s1_mb;

        r_s2_tag <= r_s1_tag;
        r_s2_neg <= r_s1_neg;
        r_s2_plo <= r_s1_ma * r_s1_mb[HW-1:0];
        r_s2_phi <= r_s1_ma * r_s1_mb[MW-1:HW];

        r_s3_tag <= r_s2_tag;
        r_s3_neg <= r_s2_neg;
        r_s3_sum <= {1'b0, r_s2_phi, {HW{1'b0}}} + SUMW'(r_s2_plo);

        r_s4_tag <= r_s3_tag;
        r_s4_neg <= r_s3_neg;
        r_s4_mag <= n_s4_mag;

        r_s5_tag <= r_s4_tag;
        r_s5_res <= n_s5_res;
    end

    assign w_res = AW'(r_s5_res);

    // Input latch, saturation step and accumulator writeback
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_xi <= i_i_in;
            r_xq <= i_q_in;
        end
        if (i_cmd.sat) begin
            r_oq <= sat_osc(r_acc_q);
            r_oi <= sat_osc(r_acc_i);
            r_g  <= sat_osc(r_acc_g);
        end
        if (r_v5) begin
            case (r_s5_tag)
                TAG_QC:   r_acc_q <= w_res;
                TAG_IS:   r_acc_q <= r_acc_q - w_res;
                TAG_IC:   r_acc_i <= w_res;
                TAG_QS:   r_acc_i <= r_acc_i + w_res;
                TAG_QQ:   r_acc_g <= GAIN_REF - w_res;
                TAG_II:   r_acc_g <= r_acc_g - w_res;
                TAG_XIOQ: r_acc_q <= w_res;
                TAG_XQOI: r_acc_q <= r_acc_q + w_res;
                TAG_XQOQ: r_acc_i <= w_res;
                TAG_XIOI: r_acc_i <= r_acc_i - w_res;
                TAG_YI:   r_yi    <= sat_smp(w_res);
                TAG_YQ:   r_yq    <= sat_smp(w_res);
                default: ;
            endcase
        end
    end

    // Oscillator state and output valid
    assign w_out_take = r_out_valid && !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vq        <= VEC_ONE;
            r_vi        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_v5 && (r_s5_tag == TAG_GQ)) r_vq <= sat_osc(w_res);
            if (r_v5 && (r_s5_tag == TAG_GI)) r_vi <= sat_osc(w_res);
            if (r_v5 && (r_s5_tag == TAG_YQ)) begin
                r_out_valid <= 1'b1;
            end else if (w_out_take) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_i_out         = r_yi;
    assign o_q_out         = r_yq;
    assign o_stat.busy     = r_v1 | r_v2 | r_v3 | r_v4 | r_v5;
    assign o_stat.out_free = !r_out_valid || !i_out_stall;

endmodule

@@ rtl/core/quadrature_nco_mixer.sv @@
`timescale 1ns / 1ps
// Top level of the quadrature NCO mixer: controller plus datapath.
// Depends on qnm_pkg, qnm_ctrl and qnm_datapath.
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+-----------------------
//  input   | in        | i_in_valid / o_in_stall   | i_i_in, i_q_in
//  output  | out       | o_out_valid / i_out_stall | o_i_out, o_q_out
//  config  | in        | i_cfg_we                  | i_cfg_addr, i_cfg_wdata
//
// No new item is accepted until the current one is done: 14 products
// share one five-stage multiplier, issued in three dependent phases
// (rotate and magnitude, gain and mix, output scale) with a pipeline
// drain between phases. The next item is accepted while a result still
// sits in the output register; the output scale phase waits for it to
// be taken. Reset is synchronous and needs no clearing pass.
module quadrature_nco_mixer #(
    parameter int SAMPLE_WIDTH = 16,
    parameter int OSC_WIDTH    = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [qnm_pkg::CFG_IDX_W-1:0]       i_cfg_addr,
    input  logic [qnm_pkg::CFG_W-1:0]           i_cfg_wdata,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic signed [SAMPLE_WIDTH-1:0]      i_i_in,
    input  logic signed [SAMPLE_WIDTH-1:0]      i_q_in,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic signed [SAMPLE_WIDTH-1:0]      o_i_out,
    output logic signed [SAMPLE_WIDTH-1:0]      o_q_out
);
    import qnm_pkg::*;

    t_cmd  w_cmd;
    t_stat w_stat;

    // Phase sequencer
    qnm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    // Arithmetic and state
    qnm_datapath #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .OSC_WIDTH    (OSC_WIDTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_i_in      (i_i_in),
        .i_q_in      (i_q_in),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_i_out     (o_i_out),
        .o_q_out     (o_q_out),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat)
    );

endmodule

@@ rtl/core/qnm_checker.sv @@
`timescale 1ns / 1ps
// Port-level assertions for the quadrature NCO mixer, bound to the top level.
// Depends on quadrature_nco_mixer.
module qnm_checker #(
    parameter int SAMPLE_WIDTH = 16
) (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_in_valid,
    input logic                           o_in_stall,
    input logic                           o_out_valid,
    input logic                           i_out_stall,
    input logic signed [SAMPLE_WIDTH-1:0] o_i_out,
    input logic signed [SAMPLE_WIDTH-1:0] o_q_out
);

    // One item in work at a time: an accepted transaction closes the input
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input not stalled after accepted transaction");

    // A result only appears while an item is in work
    a_result_from_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> o_in_stall)
        else $error("result appeared with no item in work");

    // Stalled result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> o_out_valid)
        else $error("output valid dropped while stalled");

    // Stalled result payload stays put
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> ($stable(o_i_out) && $stable(o_q_out)))
        else $error("output payload changed while stalled");

endmodule

bind quadrature_nco_mixer qnm_checker #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_qnm_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_i_out     (o_i_out),
    .o_q_out     (o_q_out)
);

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for quadrature_nco_mixer: directed and random I/Q samples,
// several rotation and gain settings, random idling on both channels.
// Depends on qnm_pkg and the quadrature_nco_mixer RTL.
module tb;
    import qnm_pkg::*;

    localparam int SW        = 16;
    localparam int OSC_W     = 32;
    localparam int OSC_FRAC  = OSC_W - 2;
    localparam int LONG_HOLD = 400;
    localparam int DRAIN_CYC = 40;
    localparam longint GAIN_REF = ((longint'(39) << OSC_FRAC) + 10) / 20;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    typedef struct {
        logic signed [SW-1:0] i;
        logic signed [SW-1:0] q;
    } sample_t;

    logic                    i_clk       = 1'b0;
    logic                    i_rst_n     = 1'b0;
    logic                    i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]    i_cfg_addr  = '0;
    logic [CFG_W-1:0]        i_cfg_wdata = '0;
    logic                    i_in_valid  = 1'b0;
    logic                    o_in_stall;
    logic signed [SW-1:0]    i_i_in      = '0;
    logic signed [SW-1:0]    i_q_in      = '0;
    logic                    o_out_valid;
    logic                    i_out_stall = 1'b0;
    logic signed [SW-1:0]    o_i_out;
    logic signed [SW-1:0]    o_q_out;

    // Predictor state and register shadows
    longint osc_q, osc_i;
    longint cos_step, sin_step, out_gain;

    sample_t to_send[$];
    sample_t shifted_samples[$];
    sample_t tx_item, want;
    int      queued_cnt = 0;
    int      sent_cnt   = 0;
    int      err_cnt    = 0;
    int      tx_gap     = 0;
    int      rx_stall   = 0;
    int      rx_run     = 0;
    int      rx_hold    = 0;
    int      hold_reqs  = 0;
    int      hold_seen  = 0;
    bit      idle_on    = 1'b0;

    quadrature_nco_mixer #(
        .SAMPLE_WIDTH(SW),
        .OSC_WIDTH   (OSC_W)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_wdata(i_cfg_wdata),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_i_in     (i_i_in),
        .i_q_in     (i_q_in),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_i_out    (o_i_out),
        .o_q_out    (o_q_out)
    );

    always #5 i_clk = ~i_clk;

    // round(a*b / 2^sh), half away from zero, magnitude clamped to 2^60
    function automatic longint mul_round(longint a, longint b, int sh);
        logic [63:0]  ua, ub;
        logic [127:0] prod;
        logic [63:0]  mag;
        logic         neg;
        neg  = (a < 0) != (b < 0);
        ua   = (a < 0) ? -a : a;
        ub   = (b < 0) ? -b : b;
        prod = {64'd0, ua} * {64'd0, ub};
        prod = (prod + (128'd1 << (sh - 1))) >> sh;
        mag  = (prod > (128'd1 << 60)) ? (64'd1 << 60) : prod[63:0];
        return neg ? -longint'(mag) : longint'(mag);
    endfunction

    function automatic longint sat_to(longint x, int w);
        longint hi, lo;
        hi = (longint'(1) << (w - 1)) - 1;
        lo = -hi - 1;
        if (x > hi) return hi;
        if (x < lo) return lo;
        return x;
    endfunction

    // Advance the oscillator by one step and mix one sample with it
    function automatic sample_t mix_sample(logic signed [SW-1:0] si, logic signed [SW-1:0] sq);
        longint  xi, xq, oq, oi, g, pi, pq;
        sample_t r;
        xi = longint'(si);
        xq = longint'(sq);
        oq = sat_to(mul_round(osc_q, cos_step, ROT_FRAC)
                    - mul_round(osc_i, sin_step, ROT_FRAC), OSC_W);
        oi = sat_to(mul_round(osc_i, cos_step, ROT_FRAC)
                    + mul_round(osc_q, sin_step, ROT_FRAC), OSC_W);
        g  = sat_to(GAIN_REF - (mul_round(osc_q, osc_q, OSC_FRAC)
                    + mul_round(osc_i, osc_i, OSC_FRAC)), OSC_W);
        osc_q = sat_to(mul_round(g, oq, OSC_FRAC), OSC_W);
        osc_i = sat_to(mul_round(g, oi, OSC_FRAC), OSC_W);
        pi = mul_round(xi, oq, OSC_FRAC) + mul_round(xq, oi, OSC_FRAC);
        pq = mul_round(xq, oq, OSC_FRAC) - mul_round(xi, oi, OSC_FRAC);
        r.i = SW'(sat_to(mul_round(pi, out_gain, GAIN_FRAC), SW));
        r.q = SW'(sat_to(mul_round(pq, out_gain, GAIN_FRAC), SW));
        return r;
    endfunction

    // Idle length: mostly zero or short, now and then long
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 15);
        return $urandom_range(30, 80);
    endfunction

    function automatic logic signed [SW-1:0] rand_sample();
        case ($urandom_range(0, 9))
            0:       return 16'sh7fff;
            1:       return 16'sh8000;
            2:       return SW'($urandom_range(0, 64)) - 16'sd32;
            default: return SW'($urandom);
        endcase
    endfunction

    // Sender: one transaction per acceptance, prediction at acceptance
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                shifted_samples.push_back(mix_sample(i_i_in, i_q_in));
                sent_cnt++;
            end
            if (!i_in_valid || !o_in_stall) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                    i_in_valid <= 1'b0;
                end else if (to_send.size() > 0) begin
                    tx_item = to_send.pop_front();
                    i_in_valid <= 1'b1;
                    i_i_in     <= tx_item.i;
                    i_q_in     <= tx_item.q;
                    tx_gap     = idle_on ? idle_len() : 0;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver stall: requested long hold-off, else random runs while idling is on
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else if (hold_seen != hold_reqs) begin
            hold_seen   = hold_reqs;
            rx_hold     = LONG_HOLD;
            i_out_stall <= 1'b1;
        end else if (rx_hold > 0) begin
            rx_hold--;
            i_out_stall <= 1'b1;
        end else if (!idle_on) begin
            i_out_stall <= 1'b0;
        end else if (rx_stall > 0) begin
            rx_stall--;
            i_out_stall <= 1'b1;
        end else if (rx_run > 0) begin
            rx_run--;
            i_out_stall <= 1'b0;
        end else begin
            rx_stall    = idle_len();
            rx_run      = $urandom_range(0, 12);
            i_out_stall <= 1'b0;
        end
    end

    // Result checker
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (shifted_samples.size() == 0) begin
                $error("unexpected result: i_out=%0d q_out=%0d", o_i_out, o_q_out);
                err_cnt++;
            end else begin
                want = shifted_samples.pop_front();
                if (o_i_out !== want.i) begin
                    $error("i_out mismatch: expected %0d, actual %0d", want.i, o_i_out);
                    err_cnt++;
                end
                if (o_q_out !== want.q) begin
                    $error("q_out mismatch: expected %0d, actual %0d", want.q, o_q_out);
                    err_cnt++;
                end
            end
        end
    end

    task automatic push_sample(logic signed [SW-1:0] si, logic signed [SW-1:0] sq);
        sample_t s;
        s.i = si;
        s.q = sq;
        to_send.push_back(s);
        queued_cnt++;
    endtask

    task automatic push_random(int n);
        repeat (n) push_sample(rand_sample(), rand_sample());
    endtask

    task automatic wait_drained();
        while (to_send.size() != 0 || sent_cnt != queued_cnt || shifted_samples.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Register write; only issued while the block is idle
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= data;
        case (idx)
            CFG_ROT_COS:  cos_step = longint'($signed(data));
            CFG_ROT_SIN:  sin_step = longint'($signed(data));
            CFG_MIX_GAIN: out_gain = longint'(data[MG_W-1:0]);
            default:      ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_rotation(real amp);
        real ang;
        ang = $urandom_range(0, 65535) * 6.283185307179586 / 65536.0;
        write_reg(CFG_ROT_COS, CFG_W'($rtoi($cos(ang) * amp * 1073741824.0)));
        write_reg(CFG_ROT_SIN, CFG_W'($rtoi($sin(ang) * amp * 1073741824.0)));
    endtask

    task automatic set_gain(int g);
        write_reg(CFG_MIX_GAIN, {16'($urandom), 16'(g)});
    endtask

    // Main sequence
    initial begin
        cos_step = longint'(ROT_COS_RST);
        sin_step = longint'(ROT_SIN_RST);
        out_gain = longint'(MIX_GAIN_RST);
        osc_q    = longint'(1) << OSC_FRAC;
        osc_i    = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // Directed: reset settings, field extremes and bit patterns
        push_sample(16'sh0000, 16'sh0000);
        push_sample(16'sh7fff, 16'sh7fff);
        push_sample(16'sh8000, 16'sh8000);
        push_sample(16'sh7fff, 16'sh8000);
        push_sample(16'sh8000, 16'sh7fff);
        push_sample(16'sh5555, 16'shaaaa);
        push_sample(16'shaaaa, 16'sh5555);
        push_sample(16'sh0001, 16'shffff);
        wait_drained();

        // Directed: unnormalized extreme rotation, full output scale (saturation)
        write_reg(CFG_ROT_COS, 32'h7fffffff);
        write_reg(CFG_ROT_SIN, 32'h80000000);
        set_gain(65535);
        push_sample(16'sh7fff, 16'sh7fff);
        push_sample(16'sh8000, 16'sh7fff);
        push_sample(16'sh8000, 16'sh8000);
        push_sample(16'sh7fff, 16'sh8000);
        push_sample(16'sh4000, 16'shc000);
        push_sample(16'sh0000, 16'sh7fff);
        wait_drained();

        // Directed: opposite extremes, zero output scale
        write_reg(CFG_ROT_COS, 32'h80000000);
        write_reg(CFG_ROT_SIN, 32'h7fffffff);
        set_gain(0);
        push_sample(16'sh7fff, 16'sh8000);
        push_sample(16'sh8000, 16'sh7fff);
        push_sample(16'sh1234, 16'shedcb);
        wait_drained();

        // Directed: unknown register index is ignored
        write_reg(CFG_UNUSED, $urandom);
        set_gain(32767);
        push_sample(16'sh7fff, 16'sh7fff);
        push_sample(16'sh8000, 16'sh0001);
        push_sample(16'sh2000, 16'sh6000);
        wait_drained();

        // Random phases over a range of settings
        for (int p = 0; p < 10; p++) begin
            idle_on = 1'b0;
            case (p % 5)
                0: begin
                    set_rotation(1.0);
                    set_gain($urandom_range(16000, 20000));
                end
                1: begin
                    write_reg(CFG_ROT_COS, $urandom);
                    write_reg(CFG_ROT_SIN, $urandom);
                    set_gain($urandom_range(0, 65535));
                end
                2: begin
                    write_reg(CFG_ROT_COS, ROT_COS_RST);
                    write_reg(CFG_ROT_SIN, ROT_SIN_RST);
                    set_gain(MIX_GAIN_RST);
                end
                3: begin
                    set_rotation(1.0);
                    set_gain(($urandom_range(0, 1) != 0) ? 65535 : 0);
                end
                default: begin
                    set_rotation(1.0 + $urandom_range(0, 90) / 100.0);
                    set_gain($urandom_range(0, 65535));
                end
            endcase
            if (p == 4) begin
                // Receiver holds off while the sender keeps offering
                hold_reqs++;
                push_random(125);
            end else if (p == 6) begin
                // Sender pauses until all results are back
                idle_on = 1'b1;
                push_random(60);
                wait_drained();
                push_random(65);
            end else begin
                idle_on = (p % 3 != 1);
                push_random(125);
            end
            wait_drained();
        end

        idle_on = 1'b0;
        repeat (DRAIN_CYC) @(posedge i_clk);
        if (err_cnt == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end

    // Run limit
    initial begin
        #20_000_000;
        $display("tb: FAIL");
        $finish;
    end

endmodule

@@ files.f @@
rtl/core/qnm_pkg.sv
rtl/core/qnm_ctrl.sv
rtl/core/qnm_datapath.sv
rtl/core/quadrature_nco_mixer.sv
rtl/core/qnm_checker.sv
tb/tb.sv
